/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/efa_pkg.sv */
// ----------------------------------------------------------------------------
// efa_pkg
// Types and constants shared by the event frame accumulator.
// ----------------------------------------------------------------------------
package efa_pkg;

    localparam int COORD_BITS  = 8;
    localparam int SIZE_BITS   = 9;
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COUNT_BITS  = 16;
    localparam int WORD_BITS   = 2 * COUNT_BITS;
    localparam int ADDR_BITS   = 2 * COORD_BITS;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;

    localparam logic [SIZE_BITS-1:0]  FRAME_SIZE_RESET = SIZE_BITS'(256);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX        = {COUNT_BITS{1'b1}};

    // command codes
    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ       = 1'b1;

    // configuration register index (paddr[2])
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  polarity;
    } efa_in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        positive_count;
        logic [COUNT_BITS-1:0]        negative_count;
        logic signed [COUNT_BITS-1:0] net_count;
        logic [COUNT_BITS-1:0]        total_count;
        logic                         in_frame;
    } efa_out_t;

    // store write request
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
    } efa_wr_t;

endpackage

/* sv/event_frame_accumulator.sv */
// ----------------------------------------------------------------------------
// event_frame_accumulator
// Per-pixel positive/negative event counts in a frame store, with
// read-and-clear of single pixels.
//
//  channel  | ports          | moves
//  ---------+----------------+-------------------------------------------
//  input    | s_valid/s_ready| efa_in_t: accumulate event or read pixel
//  result   | m_valid/m_ready| efa_out_t: one item per read command
//  config   | APB psel..     | frame_width @0x0, frame_height @0x4
//
// One item per cycle while no read stalls: store read at accept, modify and
// write back in the modify stage, forwarding when two items in a row hit one
// pixel. A zeroing sweep of all 65536 words after reset holds s_ready low.
// A read command stalls in the modify stage while the result register is
// full and not taken; accumulate commands never wait on the result side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module event_frame_accumulator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  efa_pkg::efa_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output efa_pkg::efa_out_t   m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [efa_pkg::SIZE_BITS-1:0] frame_width;
    logic [efa_pkg::SIZE_BITS-1:0] frame_height;
    logic                          clearing;
    logic                          accept;
    logic                          in_inside;
    logic [efa_pkg::ADDR_BITS-1:0] in_addr;
    logic [efa_pkg::WORD_BITS-1:0] rd_data;
    logic [efa_pkg::WORD_BITS-1:0] cur_word;
    logic [efa_pkg::WORD_BITS-1:0] new_word;
    efa_pkg::efa_out_t             result;
    efa_pkg::efa_wr_t              wr_req;
    logic                          s1_fire;
    logic                          s1_is_read;

    // modify stage
    logic                          s1_valid_reg;
    efa_pkg::efa_in_t              s1_item_reg;
    logic                          s1_inside_reg;
    logic [efa_pkg::ADDR_BITS-1:0] s1_addr_reg;
    // last write-back, for forwarding
    logic                          wb_valid_reg;
    logic [efa_pkg::ADDR_BITS-1:0] wb_addr_reg;
    logic [efa_pkg::WORD_BITS-1:0] wb_data_reg;
    // result register
    logic                          m_valid_reg;
    efa_pkg::efa_out_t             m_data_reg;

    efa_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    assign pready = 1'b1;

    assign in_inside = ({1'b0, s_data.pixel_x} < frame_width) &&
                       ({1'b0, s_data.pixel_y} < frame_height) &&
                       (32'(s_data.pixel_x) < efa_pkg::MAX_WIDTH) &&
                       (32'(s_data.pixel_y) < efa_pkg::MAX_HEIGHT);
    assign in_addr   = {s_data.pixel_y, s_data.pixel_x};

    assign s1_is_read = s1_item_reg.command == efa_pkg::CMD_READ;
    assign s1_fire    = s1_valid_reg && (!s1_is_read || !m_valid_reg || m_ready);
    assign s_ready    = !clearing && (!s1_valid_reg || s1_fire);
    assign accept     = s_valid && s_ready;

    efa_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (in_addr),
        .rd_data  (rd_data),
        .wr_req   (wr_req),
        .clearing (clearing)
    );

    // the previous item's write lands on the edge this item's read was taken
    assign cur_word = (wb_valid_reg && wb_addr_reg == s1_addr_reg) ? wb_data_reg : rd_data;

    efa_calc u_calc (
        .item     (s1_item_reg),
        .in_area  (s1_inside_reg),
        .cur_word (cur_word),
        .new_word (new_word),
        .result   (result)
    );

    always_comb begin
        wr_req.en   = s1_fire && s1_inside_reg;
        wr_req.addr = s1_addr_reg;
        wr_req.data = new_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                wb_valid_reg <= wr_req.en;
            end
            if (s1_fire && s1_is_read) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg   <= s_data;
            s1_inside_reg <= in_inside;
            s1_addr_reg   <= in_addr;
        end
        if (s1_fire) begin
            wb_addr_reg <= wr_req.addr;
            wb_data_reg <= wr_req.data;
        end
        if (s1_fire && s1_is_read) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPL(a_no_accept_in_sweep, clearing, !s_ready, "item accepted during store sweep")
    `ASSERT_IMPL(a_no_wb_in_sweep, wr_req.en, !clearing, "write-back during store sweep")
    `ASSERT_NEXT(a_read_gives_result, s1_fire && s1_is_read, m_valid, "read item lost its result")
    `ASSERT_IMPL(a_out_of_frame_zero, m_valid && !m_data.in_frame, m_data.total_count == '0,
                 "out-of-frame read with nonzero counts")

endmodule

/* sv/efa_regs.sv */
// ----------------------------------------------------------------------------
// efa_regs
// APB register file: frame width and frame height.
// ----------------------------------------------------------------------------
module efa_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic [efa_pkg::SIZE_BITS-1:0]   frame_width,
    output logic [efa_pkg::SIZE_BITS-1:0]   frame_height
);

    logic [efa_pkg::SIZE_BITS-1:0] frame_width_reg;
    logic [efa_pkg::SIZE_BITS-1:0] frame_height_reg;
    logic                          wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= efa_pkg::FRAME_SIZE_RESET;
            frame_height_reg <= efa_pkg::FRAME_SIZE_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                efa_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[efa_pkg::SIZE_BITS-1:0];
                efa_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[efa_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            efa_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            efa_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign frame_width  = frame_width_reg;
    assign frame_height = frame_height_reg;

endmodule

/* sv/efa_store.sv */
// ----------------------------------------------------------------------------
// efa_store
// Frame store: one word per pixel, positive count high, negative count low.
// Registered read, one write port, zeroing sweep after reset.
// ----------------------------------------------------------------------------
module efa_store (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [efa_pkg::ADDR_BITS-1:0]   rd_addr,
    output logic [efa_pkg::WORD_BITS-1:0]   rd_data,
    input  efa_pkg::efa_wr_t                wr_req,
    output logic                            clearing
);

    logic [efa_pkg::WORD_BITS-1:0] mem [efa_pkg::STORE_DEPTH];
    logic [efa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          clear_reg;
    logic [efa_pkg::ADDR_BITS-1:0] clear_addr_reg;
    logic                          we;
    logic [efa_pkg::ADDR_BITS-1:0] wa;
    logic [efa_pkg::WORD_BITS-1:0] wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_reg) begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == {efa_pkg::ADDR_BITS{1'b1}}) begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (clear_reg) begin
            we = 1'b1;
            wa = clear_addr_reg;
            wd = '0;
        end else begin
            we = wr_req.en;
            wa = wr_req.addr;
            wd = wr_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // read-during-write returns the old word; the caller forwards
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

/* sv/efa_calc.sv */
// ----------------------------------------------------------------------------
// efa_calc
// Modify step: saturating increment on accumulate, clear and report on read.
// ----------------------------------------------------------------------------
module efa_calc (
    input  efa_pkg::efa_in_t                item,
    input  logic                            in_area,
    input  logic [efa_pkg::WORD_BITS-1:0]   cur_word,
    output logic [efa_pkg::WORD_BITS-1:0]   new_word,
    output efa_pkg::efa_out_t               result
);

    localparam logic signed [efa_pkg::COUNT_BITS:0] NET_MAX =
        (efa_pkg::COUNT_BITS+1)'((1 << (efa_pkg::COUNT_BITS-1)) - 1);
    localparam logic signed [efa_pkg::COUNT_BITS:0] NET_MIN =
        (efa_pkg::COUNT_BITS+1)'(-(1 << (efa_pkg::COUNT_BITS-1)));

    logic [efa_pkg::COUNT_BITS-1:0]        pos;
    logic [efa_pkg::COUNT_BITS-1:0]        neg;
    logic [efa_pkg::COUNT_BITS-1:0]        pos_inc;
    logic [efa_pkg::COUNT_BITS-1:0]        neg_inc;
    logic signed [efa_pkg::COUNT_BITS:0]   diff;
    logic [efa_pkg::COUNT_BITS:0]          sum;

    always_comb begin
        if (in_area) begin
            pos = cur_word[efa_pkg::WORD_BITS-1:efa_pkg::COUNT_BITS];
            neg = cur_word[efa_pkg::COUNT_BITS-1:0];
        end else begin
            pos = '0;
            neg = '0;
        end

        pos_inc = pos;
        neg_inc = neg;
        if (item.polarity) begin
            if (pos != efa_pkg::COUNT_MAX) pos_inc = pos + 1'b1;
        end else begin
            if (neg != efa_pkg::COUNT_MAX) neg_inc = neg + 1'b1;
        end

        if (item.command == efa_pkg::CMD_READ) begin
            new_word = '0;
        end else begin
            new_word = {pos_inc, neg_inc};
        end

        diff = $signed({1'b0, pos}) - $signed({1'b0, neg});
        sum  = {1'b0, pos} + {1'b0, neg};

        result.positive_count = pos;
        result.negative_count = neg;
        if (diff > NET_MAX) begin
            result.net_count = NET_MAX[efa_pkg::COUNT_BITS-1:0];
        end else if (diff < NET_MIN) begin
            result.net_count = NET_MIN[efa_pkg::COUNT_BITS-1:0];
        end else begin
            result.net_count = diff[efa_pkg::COUNT_BITS-1:0];
        end
        result.total_count = sum[efa_pkg::COUNT_BITS] ? efa_pkg::COUNT_MAX
                                                       : sum[efa_pkg::COUNT_BITS-1:0];
        result.in_frame    = in_area;
    end

endmodule
